/* rtl/bf33_pkg.sv */
// Shared constants, codes and types of the 3x3 box filter.
// Used by every module of the block; depends on nothing.
package bf33_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 4096;
	localparam int MIN_DIM      = 3;
	localparam int PIX_W        = 8;
	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_IDX_W    = 1;
	localparam int ROW_W        = 12;
	localparam int HGT_W        = 13;
	localparam int SUM_W        = 12;

	// Division by nine as a multiplication by ceil(2^16 / 9); exact for any sum of nine pixels.
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 16;
	localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_FLUSH = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		SEL_AVG,
		SEL_CENTER,
		SEL_LAST,
		SEL_UPPER,
		SEL_MIDDLE
	} sel_t;

	typedef struct packed {
		logic rd;
		logic shift;
		logic emit;
		sel_t sel;
		logic frame_end;
	} op_t;

	function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] total);
		logic [SUM_W+RECIP_W-1:0] prod;
		prod = (SUM_W+RECIP_W)'(total) * (SUM_W+RECIP_W)'(RECIP_9);
		return prod[RECIP_SHIFT +: PIX_W];
	endfunction

endpackage

/* rtl/bf33_if.sv */
// Channel interfaces of the 3x3 box filter: pixel input, filtered result and register writes.
// Depends on bf33_pkg for field widths.
interface bf33_pix_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [bf33_pkg::PIX_W-1:0]    pixel_in;

	modport source(output valid, req_type, pixel_in, input ready);
	modport sink(input valid, req_type, pixel_in, output ready);
endinterface

interface bf33_res_if;
	logic                          valid;
	logic                          ready;
	logic [bf33_pkg::PIX_W-1:0]    pixel_out;
	logic                          frame_end;

	modport source(output valid, pixel_out, frame_end, input ready);
	modport sink(input valid, pixel_out, frame_end, output ready);
endinterface

interface bf33_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bf33_pkg::CFG_IDX_W-1:0]   index;
	logic [bf33_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* rtl/bf33_ctrl.sv */
// Frame geometry registers and raster counters; decides what each accepted transaction does.
// Depends on bf33_pkg.
module bf33_ctrl #(
	parameter int MAX_WIDTH = bf33_pkg::MAX_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr,
	input  logic [bf33_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [bf33_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               accept,
	input  logic                               req_type,
	output bf33_pkg::op_t                      op,
	output logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
	output logic [$clog2(MAX_WIDTH)-1:0]       last_addr
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = COL_W + 1;
	localparam int HGT_W = bf33_pkg::HGT_W;
	localparam int ROW_W = bf33_pkg::ROW_W;

	logic [bf33_pkg::CFG_WIDTH_W-1:0]  width_q;
	logic [bf33_pkg::CFG_HEIGHT_W-1:0] height_q;
	logic [COL_W-1:0] in_col_q, out_col_q;
	logic [HGT_W-1:0] in_row_q;
	logic [ROW_W-1:0] out_row_q;

	logic [WID_W-1:0] w;
	logic [HGT_W-1:0] h;
	logic             clr;
	logic [COL_W-1:0] ic, oc, ic_n, oc_n;
	logic [HGT_W-1:0] ir, ir_n;
	logic [ROW_W-1:0] orow, orow_n;
	logic [WID_W-1:0] ic_inc, oc_inc;
	logic             ir_full, interior, end_pos;

	always_comb begin
		if (width_q < bf33_pkg::CFG_WIDTH_W'(bf33_pkg::MIN_DIM)) begin
			w = WID_W'(bf33_pkg::MIN_DIM);
		end else if (width_q > MAX_WIDTH) begin
			w = WID_W'(MAX_WIDTH);
		end else begin
			w = WID_W'(width_q);
		end
		if (height_q < bf33_pkg::CFG_HEIGHT_W'(bf33_pkg::MIN_DIM)) begin
			h = HGT_W'(bf33_pkg::MIN_DIM);
		end else if (height_q > bf33_pkg::MAX_HEIGHT) begin
			h = HGT_W'(bf33_pkg::MAX_HEIGHT);
		end else begin
			h = HGT_W'(height_q);
		end
	end

	// A height change can leave the counters beyond the frame; the frame is then dropped.
	assign clr  = (in_row_q > h) || ({1'b0, out_row_q} >= h);
	assign ic   = clr ? '0 : in_col_q;
	assign ir   = clr ? '0 : in_row_q;
	assign oc   = clr ? '0 : out_col_q;
	assign orow = clr ? '0 : out_row_q;

	assign ic_inc   = {1'b0, ic} + WID_W'(1);
	assign oc_inc   = {1'b0, oc} + WID_W'(1);
	assign ir_full  = ir >= h;
	assign end_pos  = ({1'b0, orow} + HGT_W'(1) == h) && (oc_inc >= w);
	assign interior = (orow != '0) && ({1'b0, orow} + HGT_W'(2) <= h) &&
	                  (oc != '0) && ({1'b0, oc} + WID_W'(2) <= w);
	assign last_addr = COL_W'(w - WID_W'(1));

	always_comb begin
		op     = '0;
		op.sel = bf33_pkg::SEL_CENTER;
		rd_addr = oc;
		if (req_type == bf33_pkg::REQ_PIXEL) begin
			rd_addr = ic;
			if (!ir_full) begin
				op.rd    = 1'b1;
				op.shift = 1'b1;
				op.emit  = (ir >= HGT_W'(2)) || ((ir == HGT_W'(1)) && (ic != '0));
				if (ic == '0) begin
					op.sel = bf33_pkg::SEL_LAST;
				end else if (interior) begin
					op.sel = bf33_pkg::SEL_AVG;
				end
			end
		end else if (ir_full) begin
			op.rd   = 1'b1;
			op.emit = 1'b1;
			op.sel  = ({1'b0, orow} + HGT_W'(2) == ir) ? bf33_pkg::SEL_UPPER
			                                           : bf33_pkg::SEL_MIDDLE;
		end
		op.frame_end = op.emit && end_pos;
	end

	always_comb begin
		ic_n   = ic;
		ir_n   = ir;
		oc_n   = oc;
		orow_n = orow;
		if (op.shift) begin
			if (ic_inc >= w) begin
				ic_n = '0;
				ir_n = ir + HGT_W'(1);
			end else begin
				ic_n = ic_inc[COL_W-1:0];
			end
		end
		if (op.emit) begin
			if (op.frame_end) begin
				ic_n   = '0;
				ir_n   = '0;
				oc_n   = '0;
				orow_n = '0;
			end else if (oc_inc >= w) begin
				oc_n   = '0;
				orow_n = orow + ROW_W'(1);
			end else begin
				oc_n = oc_inc[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= bf33_pkg::CFG_WIDTH_W'(640);
			height_q  <= bf33_pkg::CFG_HEIGHT_W'(480);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					bf33_pkg::REG_IMAGE_WIDTH: begin
						width_q <= cfg_data[bf33_pkg::CFG_WIDTH_W-1:0];
					end
					bf33_pkg::REG_IMAGE_HEIGHT: begin
						height_q <= cfg_data[bf33_pkg::CFG_HEIGHT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				in_col_q  <= ic_n;
				in_row_q  <= ir_n;
				out_col_q <= oc_n;
				out_row_q <= orow_n;
			end
		end
	end

	a_frame_end_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op.frame_end |=> (in_col_q == '0) && (in_row_q == '0) &&
		                           (out_col_q == '0) && (out_row_q == '0))
		else $error("counters not rewound after the last pixel of a frame");

endmodule

/* rtl/bf33_line_store.sv */
// Two line memories (rows two and one above the incoming row) with registered reads.
// Forwards a write that lands on the address read in the same cycle. Depends on bf33_pkg.
module bf33_line_store #(
	parameter int MAX_WIDTH = bf33_pkg::MAX_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
	input  logic [$clog2(MAX_WIDTH)-1:0]       last_addr,
	input  logic                               wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]       wr_addr,
	input  logic [bf33_pkg::PIX_W-1:0]         wr_upper,
	input  logic [bf33_pkg::PIX_W-1:0]         wr_middle,
	output logic [bf33_pkg::PIX_W-1:0]         upper,
	output logic [bf33_pkg::PIX_W-1:0]         upper_last,
	output logic [bf33_pkg::PIX_W-1:0]         middle
);

	localparam int PIX_W = bf33_pkg::PIX_W;

	logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [PIX_W-1:0] upper_rd_q, last_rd_q, middle_rd_q;
	logic [PIX_W-1:0] fwd_upper_q, fwd_middle_q;
	logic             fwd_a_q, fwd_b_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			upper_rd_q  <= upper_mem[rd_addr];
			last_rd_q   <= upper_mem[last_addr];
			middle_rd_q <= middle_mem[rd_addr];
		end
		if (wr_en) begin
			upper_mem[wr_addr]  <= wr_upper;
			middle_mem[wr_addr] <= wr_middle;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_upper_q  <= wr_upper;
			fwd_middle_q <= wr_middle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_a_q <= 1'b0;
			fwd_b_q <= 1'b0;
		end else if (rd_en) begin
			fwd_a_q <= wr_en && (wr_addr == rd_addr);
			fwd_b_q <= wr_en && (wr_addr == last_addr);
		end
	end

	assign upper      = fwd_a_q ? fwd_upper_q  : upper_rd_q;
	assign middle     = fwd_a_q ? fwd_middle_q : middle_rd_q;
	assign upper_last = fwd_b_q ? fwd_upper_q  : last_rd_q;

	a_forward_same_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en && (rd_addr == wr_addr) |=>
			(upper == $past(wr_upper)) && (middle == $past(wr_middle)))
		else $error("write to the address being read was not forwarded");

endmodule

/* rtl/bf33_window.sv */
// The 3x3 window of pixel registers and the registered sum of the shifted window.
// Depends on bf33_pkg.
module bf33_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift_en,
	input  logic                          load_en,
	input  logic [bf33_pkg::PIX_W-1:0]    top,
	input  logic [bf33_pkg::PIX_W-1:0]    mid,
	input  logic [bf33_pkg::PIX_W-1:0]    pix,
	output logic [bf33_pkg::PIX_W-1:0]    center,
	output logic [bf33_pkg::SUM_W-1:0]    sum_s2
);

	localparam int PIX_W = bf33_pkg::PIX_W;
	localparam int SUM_W = bf33_pkg::SUM_W;

	logic [PIX_W-1:0] win_q [9];
	logic [PIX_W-1:0] nxt   [9];
	logic [SUM_W-1:0] row0, row1, row2;

	// Columns move left by one; the new right-hand column comes from the line stores.
	always_comb begin
		nxt[0] = win_q[1];
		nxt[1] = win_q[2];
		nxt[2] = top;
		nxt[3] = win_q[4];
		nxt[4] = win_q[5];
		nxt[5] = mid;
		nxt[6] = win_q[7];
		nxt[7] = win_q[8];
		nxt[8] = pix;
	end

	assign row0   = SUM_W'(nxt[0]) + SUM_W'(nxt[1]) + SUM_W'(nxt[2]);
	assign row1   = SUM_W'(nxt[3]) + SUM_W'(nxt[4]) + SUM_W'(nxt[5]);
	assign row2   = SUM_W'(nxt[6]) + SUM_W'(nxt[7]) + SUM_W'(nxt[8]);
	assign center = nxt[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (shift_en) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= nxt[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			sum_s2 <= row0 + row1 + row2;
		end
	end

endmodule

/* rtl/box_filter_3x3_unit.sv */
// Streaming 3x3 mean filter over an 8-bit grey raster of image_width x image_height pixels,
// fed one pixel per transaction in raster order. Interior outputs are the 3x3 neighbourhood
// sum divided by nine (truncated); pixels of the first and last row and column pass through
// unchanged. Results come out in raster order and lag the input by one row plus one pixel, so
// after the last pixel of a frame the source sends image_width + 1 flush transactions
// (req_type = 1); the last result of the frame carries frame_end. While the result side is
// not stalled, the block sustains one transaction per clock on both sides: the two line
// memories are read at the edge that accepts a pixel and written back when that pixel leaves
// the first stage, with the write forwarded to a read of the same column. A result passes in
// turn through the memory read, the window sum and the divide-by-nine multiply into the
// output register. The line memories are not cleared after reset; a first frame fills them
// before any of their contents reach an output. Geometry registers (index 0 width, index 1
// height) are out-of-range clamped to 3..MAX_WIDTH and 3..4096 and should be written only
// while no transaction is in flight. Depends on bf33_pkg, the channel interfaces, bf33_ctrl,
// bf33_line_store and bf33_window.
module box_filter_3x3_unit #(
	parameter int MAX_WIDTH = bf33_pkg::MAX_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	bf33_cfg_if.sink     cfg,
	bf33_pix_if.sink     stream,
	bf33_res_if.source   result
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int PIX_W = bf33_pkg::PIX_W;

	// Transaction decode and counters.
	logic             accept;
	bf33_pkg::op_t    op;
	logic [COL_W-1:0] rd_addr, last_addr;

	// First stage: the line memories deliver the column for this transaction.
	logic             valid_s1;
	bf33_pkg::op_t    op_s1;
	logic [COL_W-1:0] addr_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             s1_adv;

	logic [PIX_W-1:0] upper, upper_last, middle, center, raw;

	// Second stage: window sum and the pass-through value.
	logic                         valid_s2;
	logic                         avg_s2;
	logic                         fe_s2;
	logic [PIX_W-1:0]             raw_s2;
	logic [bf33_pkg::SUM_W-1:0]   sum_s2;
	logic                         s2_free, s2_adv;

	// Output register.
	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_q;
	logic             fe_q;
	logic             out_free;

	assign accept    = stream.valid && stream.ready;
	assign cfg.ready = 1'b1;

	bf33_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg.valid && cfg.ready),
		.cfg_idx  (cfg.index),
		.cfg_data (cfg.data),
		.accept   (accept),
		.req_type (stream.req_type),
		.op       (op),
		.rd_addr  (rd_addr),
		.last_addr(last_addr)
	);

	// The pipeline moves as a whole: a stage advances when the one after it has room or is
	// itself advancing, so a stalled result holds everything behind it in place. Items that
	// produce no result leave after the first stage, once their write-back is done.
	assign out_free = !out_valid_q || result.ready;
	assign s2_free  = !valid_s2 || out_free;
	assign s2_adv   = valid_s2 && out_free;
	assign s1_adv   = valid_s1 && (!op_s1.emit || s2_free);
	assign stream.ready = !valid_s1 || s1_adv;

	bf33_line_store #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept && op.rd),
		.rd_addr   (rd_addr),
		.last_addr (last_addr),
		.wr_en     (s1_adv && op_s1.shift),
		.wr_addr   (addr_s1),
		.wr_upper  (middle),
		.wr_middle (pix_s1),
		.upper     (upper),
		.upper_last(upper_last),
		.middle    (middle)
	);

	bf33_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift_en(s1_adv && op_s1.shift),
		.load_en (s1_adv && op_s1.emit),
		.top     (upper),
		.mid     (middle),
		.pix     (pix_s1),
		.center  (center),
		.sum_s2  (sum_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= '0;
		end else if (accept) begin
			valid_s1 <= op.rd;
			op_s1    <= op;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= rd_addr;
			pix_s1  <= stream.pixel_in;
		end
	end

	// Border pixels take the stored value: the start of a row closes the previous row's last
	// column from the upper store, flushes drain whichever store holds the pending row.
	always_comb begin
		case (op_s1.sel)
			bf33_pkg::SEL_LAST:   raw = upper_last;
			bf33_pkg::SEL_UPPER:  raw = upper;
			bf33_pkg::SEL_MIDDLE: raw = middle;
			default:              raw = center;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv && op_s1.emit) begin
			valid_s2 <= 1'b1;
		end else if (s2_adv) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && op_s1.emit) begin
			avg_s2 <= (op_s1.sel == bf33_pkg::SEL_AVG);
			fe_s2  <= op_s1.frame_end;
			raw_s2 <= raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			pixel_q <= avg_s2 ? bf33_pkg::div9(sum_s2) : raw_s2;
			fe_q    <= fe_s2;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.pixel_out = pixel_q;
	assign result.frame_end = fe_q;

	a_emit_reaches_s2: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && op_s1.emit |=> valid_s2)
		else $error("a result-bearing transaction was lost between the first and second stage");

	a_s2_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_free |=> valid_s2 && $stable(raw_s2) && $stable(fe_s2))
		else $error("second stage changed while the output register was full");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for box_filter_3x3_unit: streams small rasters and clamped geometry
// through the filter and checks every filtered pixel against a mean-filter predictor.
// Depends on bf33_pkg, the channel interfaces in bf33_if.sv and the box_filter_3x3_unit RTL.
module testbench;

	// Cycles of quiet on the pixel side before a register write, and after the last result
	// before the verdict.
	localparam int SETTLE_CYCLES = 8;
	// Number of random pixel and flush transactions that the filter is expected to act on.
	localparam int RANDOM_ITEMS  = 2000;

	// One planned transaction: either a pixel-side item or a register write.
	typedef struct {
		bit                              is_reg;
		bf33_pkg::req_t                  req;
		logic [bf33_pkg::PIX_W-1:0]      pix;
		bf33_pkg::reg_idx_t              idx;
		logic [bf33_pkg::CFG_DATA_W-1:0] data;
	} plan_item_t;

	typedef struct {
		logic [bf33_pkg::PIX_W-1:0] pixel_out;
		logic                       frame_end;
	} filtered_px_t;

	logic clk;
	logic arst_n;

	bf33_cfg_if cfg_ch ();
	bf33_pix_if pix_ch ();
	bf33_res_if res_ch ();

	box_filter_3x3_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.stream (pix_ch),
		.result (res_ch)
	);

	// Transactions still to be sent, and filtered pixels still owed by the block.
	plan_item_t   plan_q[$];
	filtered_px_t filtered_q[$];

	int unsigned plain_items;
	int unsigned faults;
	int unsigned settled;
	bit          pix_taken;
	bit          cfg_taken;

	// Predictor state: geometry registers, the two line stores, the 3x3 window and the
	// raster positions of the next incoming and the next outgoing pixel.
	logic [bf33_pkg::CFG_WIDTH_W-1:0]  geo_width;
	logic [bf33_pkg::CFG_HEIGHT_W-1:0] geo_height;
	logic [bf33_pkg::PIX_W-1:0]        row_above2 [bf33_pkg::MAX_WIDTH];
	logic [bf33_pkg::PIX_W-1:0]        row_above1 [bf33_pkg::MAX_WIDTH];
	logic [bf33_pkg::PIX_W-1:0]        win_px [9];
	int unsigned                       next_in_col;
	int unsigned                       next_in_row;
	int unsigned                       next_out_col;
	int unsigned                       next_out_row;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Out-of-range geometry is pulled into 3..top, as the block does.
	function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned top);
		return (raw < bf33_pkg::MIN_DIM) ? bf33_pkg::MIN_DIM : ((raw > top) ? top : raw);
	endfunction

	function automatic void restart_raster();
		next_in_col  = 0;
		next_in_row  = 0;
		next_out_col = 0;
		next_out_row = 0;
	endfunction

	// Advances the predictor by one accepted pixel-side transaction. Returns 1 when the
	// transaction releases a filtered pixel, whose value and end-of-frame flag are returned.
	function automatic bit mean_filter_step(input bf33_pkg::req_t req,
			input logic [bf33_pkg::PIX_W-1:0] pix,
			output logic [bf33_pkg::PIX_W-1:0] val, output logic last_px);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned total;
		int          r;
		logic [bf33_pkg::PIX_W-1:0] from_above2;
		logic [bf33_pkg::PIX_W-1:0] from_above1;
		logic [bf33_pkg::PIX_W-1:0] wrap_px;
		bit emit;

		w = clamp_dim(geo_width, bf33_pkg::MAX_WIDTH);
		h = clamp_dim(geo_height, bf33_pkg::MAX_HEIGHT);
		val = '0;
		last_px = 1'b0;

		// A frame left beyond the current geometry is dropped before anything else.
		if (next_in_row > h || next_out_row >= h)
			restart_raster();

		if (req == bf33_pkg::REQ_PIXEL) begin
			// Once the whole frame is in, further pixels wait for the flushes and are dropped.
			if (next_in_row >= h)
				return 1'b0;
			col = (next_in_col < bf33_pkg::MAX_WIDTH) ? next_in_col : bf33_pkg::MAX_WIDTH - 1;
			from_above2 = row_above2[col];
			from_above1 = row_above1[col];
			wrap_px     = row_above2[w - 1];
			for (r = 0; r < 3; r++) begin
				win_px[r*3]     = win_px[r*3 + 1];
				win_px[r*3 + 1] = win_px[r*3 + 2];
			end
			win_px[2] = from_above2;
			win_px[5] = from_above1;
			win_px[8] = pix;
			row_above2[col] = from_above1;
			row_above1[col] = pix;

			emit = (next_in_row >= 2) || (next_in_row == 1 && next_in_col >= 1);
			if (emit) begin
				if (next_in_col == 0) begin
					// The pixel released here is the last one of the row above, a border pixel.
					val = wrap_px;
				end else if (next_out_row >= 1 && next_out_row + 2 <= h &&
						next_out_col >= 1 && next_out_col + 2 <= w) begin
					total = 0;
					for (r = 0; r < 9; r++)
						total += win_px[r];
					val = bf33_pkg::PIX_W'(total / 9);
				end else begin
					val = win_px[4];
				end
			end

			next_in_col++;
			if (next_in_col >= w) begin
				next_in_col = 0;
				next_in_row++;
			end
			if (!emit)
				return 1'b0;
		end else begin
			// A flush only counts once the whole frame is in; it drains the last row.
			if (next_in_row < h)
				return 1'b0;
			col = (next_out_col < bf33_pkg::MAX_WIDTH) ? next_out_col : bf33_pkg::MAX_WIDTH - 1;
			val = (next_out_row + 2 == next_in_row) ? row_above2[col] : row_above1[col];
		end

		last_px = (next_out_row + 1 == h) && (next_out_col + 1 >= w);
		if (last_px) begin
			restart_raster();
		end else begin
			next_out_col++;
			if (next_out_col >= w) begin
				next_out_col = 0;
				next_out_row++;
			end
		end
		return 1'b1;
	endfunction

	task automatic report(input string what, input int want, input int got);
		faults++;
		$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endtask

	task automatic queue_write(input bf33_pkg::reg_idx_t idx,
			input logic [bf33_pkg::CFG_DATA_W-1:0] val);
		plan_item_t it;
		it.is_reg = 1'b1;
		it.req    = bf33_pkg::REQ_PIXEL;
		it.pix    = '0;
		it.idx    = idx;
		it.data   = val;
		plan_q.push_back(it);
	endtask

	task automatic queue_px(input bf33_pkg::req_t req, input logic [bf33_pkg::PIX_W-1:0] pix);
		plan_item_t it;
		it.is_reg = 1'b0;
		it.req    = req;
		it.pix    = pix;
		it.idx    = bf33_pkg::REG_IMAGE_WIDTH;
		it.data   = '0;
		plan_q.push_back(it);
	endtask

	// One well-formed frame of w x h pixels followed by w + 1 flushes, with the occasional
	// stray transaction that the block must drop: a flush while the frame is still coming in,
	// a pixel between the flushes, and a flush after the frame has drained.
	task automatic queue_frame(input int unsigned w, input int unsigned h);
		int unsigned style;
		int unsigned base;
		int unsigned k;
		logic [bf33_pkg::PIX_W-1:0] p;

		style = $urandom_range(0, 3);
		base  = (style == 3) ? ($urandom_range(0, 1) ? 255 : 0) : $urandom_range(0, 255);
		for (k = 0; k < w * h; k++) begin
			if ($urandom_range(0, 39) == 0)
				queue_px(bf33_pkg::REQ_FLUSH, bf33_pkg::PIX_W'($urandom));
			case (style)
				0: p = bf33_pkg::PIX_W'($urandom);
				1: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				2: p = bf33_pkg::PIX_W'(base + $urandom_range(0, 6) + 253);
				default: p = bf33_pkg::PIX_W'(base);
			endcase
			queue_px(bf33_pkg::REQ_PIXEL, p);
		end
		for (k = 0; k <= w; k++) begin
			if ($urandom_range(0, 19) == 0)
				queue_px(bf33_pkg::REQ_PIXEL, bf33_pkg::PIX_W'($urandom));
			queue_px(bf33_pkg::REQ_FLUSH, bf33_pkg::PIX_W'($urandom));
		end
		if ($urandom_range(0, 4) == 0)
			queue_px(bf33_pkg::REQ_FLUSH, bf33_pkg::PIX_W'($urandom));
		plain_items += w * h + w + 1;
	endtask

	// Monitor: watches every channel at the rising edge. Register writes update the
	// predictor's geometry, accepted pixel transactions are run through the predictor, and
	// each result transaction is checked against the oldest filtered pixel still owed.
	always @(posedge clk) begin : monitor
		filtered_px_t want;
		logic [bf33_pkg::PIX_W-1:0] val;
		logic last_px;

		pix_taken = 1'b0;
		cfg_taken = 1'b0;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				cfg_taken = 1'b1;
				case (bf33_pkg::reg_idx_t'(cfg_ch.index))
					bf33_pkg::REG_IMAGE_WIDTH:
						geo_width  = cfg_ch.data[bf33_pkg::CFG_WIDTH_W-1:0];
					bf33_pkg::REG_IMAGE_HEIGHT:
						geo_height = cfg_ch.data[bf33_pkg::CFG_HEIGHT_W-1:0];
					default: ;
				endcase
			end

			if (pix_ch.valid && pix_ch.ready) begin
				pix_taken = 1'b1;
				if (mean_filter_step(bf33_pkg::req_t'(pix_ch.req_type), pix_ch.pixel_in,
						val, last_px)) begin
					want.pixel_out = val;
					want.frame_end = last_px;
					filtered_q.push_back(want);
				end
			end

			if (res_ch.valid && res_ch.ready) begin
				if (filtered_q.size() == 0) begin
					faults++;
					$display("%0t ns: result mismatch, expected none, %s %0d frame_end %0b",
						$time, "actual pixel_out", res_ch.pixel_out, res_ch.frame_end);
				end else begin
					want = filtered_q.pop_front();
					if (res_ch.pixel_out !== want.pixel_out)
						report("pixel_out", want.pixel_out, res_ch.pixel_out);
					if (res_ch.frame_end !== want.frame_end)
						report("frame_end", want.frame_end, res_ch.frame_end);
				end
			end

			// Quiet time on the pixel side, used to hold register writes back until the
			// block has finished with everything it was given.
			if (pix_taken || pix_ch.valid || filtered_q.size() != 0)
				settled = 0;
			else if (settled < 1000)
				settled++;
		end
	end

	// Driver: on each falling edge it either holds a transaction that has not been taken yet,
	// or presents the next planned one. Pixels go out in bursts of random length separated by
	// random gaps; a register write waits until the pixel side has gone quiet.
	int unsigned burst_left;
	int unsigned gap_left;

	always @(negedge clk) begin : feeder
		plan_item_t nxt;

		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
			cfg_ch.valid <= 1'b0;
		end else if ((pix_ch.valid && !pix_taken) || (cfg_ch.valid && !cfg_taken)) begin
			// Transaction still pending: keep everything as it is.
		end else if (plan_q.size() == 0) begin
			pix_ch.valid <= 1'b0;
			cfg_ch.valid <= 1'b0;
		end else if (plan_q[0].is_reg) begin
			pix_ch.valid <= 1'b0;
			if (!cfg_ch.valid && settled >= SETTLE_CYCLES) begin
				nxt = plan_q.pop_front();
				cfg_ch.valid <= 1'b1;
				cfg_ch.index <= nxt.idx;
				cfg_ch.data  <= nxt.data;
			end else begin
				cfg_ch.valid <= 1'b0;
			end
		end else if (gap_left > 0) begin
			pix_ch.valid <= 1'b0;
			cfg_ch.valid <= 1'b0;
			gap_left--;
		end else begin
			nxt = plan_q.pop_front();
			cfg_ch.valid       <= 1'b0;
			pix_ch.valid       <= 1'b1;
			pix_ch.req_type    <= nxt.req;
			pix_ch.pixel_in    <= nxt.pix;
			if (burst_left > 1) begin
				burst_left--;
			end else begin
				// Now and then a long burst with no gap at all, so full-rate stretches occur.
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
					: $urandom_range(1, 30);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end
		end
	end

	// Receiver: back-pressure follows a pattern, picked at random and held for a random stretch,
	// among always ready, lightly stalled, periodically stalled and mostly stalled.
	int unsigned stall_mode;
	int unsigned stall_left;

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 128);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= ($urandom_range(0, 3) != 0);
			2: res_ch.ready <= (stall_left % 3 != 0);
			default: res_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Stimulus plan, reset and final verdict.
	initial begin
		int unsigned k;
		int unsigned sel;
		int unsigned w_raw;
		int unsigned h_raw;

		arst_n          = 1'b0;
		pix_ch.valid    = 1'b0;
		pix_ch.req_type = bf33_pkg::REQ_PIXEL;
		pix_ch.pixel_in = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = bf33_pkg::REG_IMAGE_WIDTH;
		cfg_ch.data     = '0;
		res_ch.ready    = 1'b0;
		faults          = 0;
		settled         = 0;
		pix_taken       = 1'b0;
		cfg_taken       = 1'b0;
		burst_left      = 0;
		gap_left        = 0;
		stall_mode      = 0;
		stall_left      = 0;
		plain_items     = 0;
		geo_width       = bf33_pkg::CFG_WIDTH_W'(640);
		geo_height      = bf33_pkg::CFG_HEIGHT_W'(480);
		foreach (win_px[i])
			win_px[i] = '0;
		foreach (row_above2[i]) begin
			row_above2[i] = '0;
			row_above1[i] = '0;
		end
		restart_raster();

		// Directed: the smallest frame. A flush with nothing pending, a flush while the
		// frame is still coming in, a pixel after the frame is complete, then the drain and
		// one more flush after it. Pixel values sit at both ends of the range.
		queue_write(bf33_pkg::REG_IMAGE_WIDTH, bf33_pkg::CFG_DATA_W'(bf33_pkg::MIN_DIM));
		queue_write(bf33_pkg::REG_IMAGE_HEIGHT, bf33_pkg::CFG_DATA_W'(bf33_pkg::MIN_DIM));
		queue_px(bf33_pkg::REQ_FLUSH, 8'h5A);
		for (k = 0; k < 9; k++) begin
			if (k == 4)
				queue_px(bf33_pkg::REQ_FLUSH, 8'hFF);
			queue_px(bf33_pkg::REQ_PIXEL, (k == 0 || k == 8) ? 8'h00 : 8'hFF);
		end
		queue_px(bf33_pkg::REQ_PIXEL, 8'h81);
		for (k = 0; k < 4; k++)
			queue_px(bf33_pkg::REQ_FLUSH, 8'h00);
		queue_px(bf33_pkg::REQ_FLUSH, 8'hC3);

		// Out-of-range geometry below the smallest frame, zero for the width and two for
		// the height, is pulled up by clamping.
		queue_write(bf33_pkg::REG_IMAGE_WIDTH, '0);
		queue_write(bf33_pkg::REG_IMAGE_HEIGHT, bf33_pkg::CFG_DATA_W'(2));
		queue_frame(bf33_pkg::MIN_DIM, bf33_pkg::MIN_DIM);

		// Random phases: new geometry, then one to three frames of random content.
		plain_items = 0;
		while (plain_items < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				w_raw = $urandom_range(0, 2);
			else if (sel == 1)
				w_raw = $urandom_range(13, 64);
			else
				w_raw = $urandom_range(3, 12);
			h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
			queue_write(bf33_pkg::REG_IMAGE_WIDTH, bf33_pkg::CFG_DATA_W'(w_raw));
			queue_write(bf33_pkg::REG_IMAGE_HEIGHT, bf33_pkg::CFG_DATA_W'(h_raw));
			repeat ($urandom_range(1, 3))
				queue_frame(clamp_dim(w_raw, bf33_pkg::MAX_WIDTH),
					clamp_dim(h_raw, bf33_pkg::MAX_HEIGHT));
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for the plan to run dry and every owed pixel to arrive, then keep watching for
		// the settle time so that any stray result shows.
		while (plan_q.size() != 0 || pix_ch.valid || cfg_ch.valid || filtered_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (faults == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#40000000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

/* box_filter_3x3_unit.f */
rtl/bf33_pkg.sv
rtl/bf33_if.sv
rtl/bf33_ctrl.sv
rtl/bf33_line_store.sv
rtl/bf33_window.sv
rtl/box_filter_3x3_unit.sv
tb/sv/testbench.sv
